// ===== rtl/mstp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and defaults for the Prim spanning tree block.
// Used by mstp_ctrl, mstp_dpath and minimum_spanning_tree_prim.
package mstp_pkg;

    localparam int NODE_COUNT_DEF  = 64;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int NODE_FIELD_BITS = 6;

    typedef struct packed {
        logic clr_write;
        logic load;
        logic run_init;
        logic issue;
        logic pick;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic v_last;
        logic best_found;
        logic pend_valid;
        logic out_free;
        logic root_ok;
    } status_t;

endpackage

// ===== rtl/mstp_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during write at the same address returns the old data. No dependencies.
module mstp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mstp_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the spanning tree block: clear pass, edge load, Prim sweeps.
// Depends on mstp_pkg for the command and status types.
module mstp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    input  mstp_pkg::status_t status,
    output mstp_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_SWEEP  = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_DECIDE = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_write = 1'b1;
                if (status.clr_done) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.run_init = 1'b1;
                state_next = status.root_ok ? ST_SWEEP : ST_FINISH;
            end
            ST_SWEEP: begin
                cmd.issue = 1'b1;
                if (status.v_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!status.best_found) begin
                    state_next = ST_FINISH;
                end else if (!status.pend_valid || status.out_free) begin
                    cmd.pick   = 1'b1;
                    state_next = ST_SWEEP;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_CLEAR;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/mstp_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: edge weight store, key store, visited and reachable bits,
// sweep pipeline, pending result and output register. Uses mstp_pkg, mstp_ram.
module mstp_dpath #(
    parameter int NODE_COUNT  = mstp_pkg::NODE_COUNT_DEF,
    parameter int WEIGHT_BITS = mstp_pkg::WEIGHT_BITS_DEF,
    localparam int NFB = mstp_pkg::NODE_FIELD_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mstp_pkg::cmd_t                cmd,
    output mstp_pkg::status_t             status,
    input  logic                          in_edge_valid,
    input  logic [NFB-1:0]                in_node_a,
    input  logic [NFB-1:0]                in_node_b,
    input  logic signed [WEIGHT_BITS-1:0] in_edge_weight,
    input  logic [NFB-1:0]                in_start_node,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [NFB-1:0]                out_tree_node,
    output logic signed [WEIGHT_BITS-1:0] out_tree_weight,
    output logic                          out_tree_empty,
    output logic                          out_last_result
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int AW = $clog2(NODE_COUNT * NODE_COUNT);
    localparam int EW = WEIGHT_BITS + 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(NODE_COUNT * NODE_COUNT - 1);
    localparam logic [NW-1:0] V_LAST   = NW'(NODE_COUNT - 1);

    // edge store port signals
    logic          e_we;
    logic [AW-1:0] e_waddr;
    logic [EW-1:0] e_wdata;
    logic [AW-1:0] e_raddr;
    logic [EW-1:0] e_rdata;

    // key store port signals
    logic                   k_we;
    logic [NW-1:0]          k_waddr;
    logic [WEIGHT_BITS-1:0] k_wdata;
    logic [WEIGHT_BITS-1:0] k_rdata;

    logic [AW-1:0] clr_cnt_reg;

    // load stage
    logic                   ld_act_reg;
    logic [AW-1:0]          ld_addr_reg;
    logic [WEIGHT_BITS-1:0] ld_w_reg;
    logic                   fw_valid_reg;
    logic [AW-1:0]          fw_addr_reg;
    logic [WEIGHT_BITS-1:0] fw_w_reg;

    // run state
    logic [NFB-1:0]         root_reg;
    logic [NW-1:0]          u_reg;
    logic [NW-1:0]          v_reg;
    logic                   sw_act_reg;
    logic [NW-1:0]          sw_v_reg;
    logic [NODE_COUNT-1:0]  visited_reg;
    logic [NODE_COUNT-1:0]  reach_reg;
    logic                   best_found_reg;
    logic [NW-1:0]          best_node_reg;
    logic [WEIGHT_BITS-1:0] best_key_reg;
    logic                   pend_valid_reg;
    logic [NW-1:0]          pend_node_reg;
    logic [WEIGHT_BITS-1:0] pend_w_reg;

    // output register
    logic                   m_valid_reg;
    logic [NFB-1:0]         m_node_reg;
    logic [WEIGHT_BITS-1:0] m_w_reg;
    logic                   m_empty_reg;
    logic                   m_last_reg;

    logic                   a_ok;
    logic                   b_ok;
    logic [NW-1:0]          a_idx;
    logic [NW-1:0]          b_idx;
    logic [AW-1:0]          in_addr;
    logic                   in_take;
    logic [NW-1:0]          sw_lo;
    logic [NW-1:0]          sw_hi;
    logic [AW-1:0]          sw_addr;
    logic [EW-1:0]          ld_cur;
    logic                   ld_write;
    logic                   vis;
    logic                   rch;
    logic                   upd;
    logic [WEIGHT_BITS-1:0] k_new;
    logic                   cand;
    logic                   better;
    logic                   out_free;
    logic                   root_ok;

    assign a_ok  = 32'(in_node_a) < 32'(NODE_COUNT);
    assign b_ok  = 32'(in_node_b) < 32'(NODE_COUNT);
    assign a_idx = NW'(in_node_a);
    assign b_idx = NW'(in_node_b);
    assign in_take = cmd.load && in_edge_valid && a_ok && b_ok && (in_node_a != in_node_b);
    assign in_addr = (a_idx < b_idx) ?
                     AW'(a_idx) * AW'(NODE_COUNT) + AW'(b_idx) :
                     AW'(b_idx) * AW'(NODE_COUNT) + AW'(a_idx);

    assign sw_lo   = (u_reg < v_reg) ? u_reg : v_reg;
    assign sw_hi   = (u_reg < v_reg) ? v_reg : u_reg;
    assign sw_addr = AW'(sw_lo) * AW'(NODE_COUNT) + AW'(sw_hi);

    assign root_ok  = 32'(root_reg) < 32'(NODE_COUNT);
    assign out_free = !m_valid_reg || m_tready;

    // merge rule: keep the smaller weight, forward the write of the previous cycle
    assign ld_cur   = (fw_valid_reg && fw_addr_reg == ld_addr_reg) ? {1'b1, fw_w_reg} : e_rdata;
    assign ld_write = ld_act_reg &&
                      (!ld_cur[WEIGHT_BITS] ||
                       $signed(ld_w_reg) < $signed(ld_cur[WEIGHT_BITS-1:0]));

    assign e_raddr = cmd.issue ? sw_addr : in_addr;
    assign e_we    = cmd.clr_write || ld_write;
    assign e_waddr = cmd.clr_write ? clr_cnt_reg : ld_addr_reg;
    assign e_wdata = cmd.clr_write ? '0 : {1'b1, ld_w_reg};

    // relax and select on one sweep entry
    assign vis = visited_reg[sw_v_reg];
    assign rch = reach_reg[sw_v_reg];
    assign upd = sw_act_reg && !vis && e_rdata[WEIGHT_BITS] &&
                 (!rch || $signed(e_rdata[WEIGHT_BITS-1:0]) < $signed(k_rdata));
    assign k_new  = upd ? e_rdata[WEIGHT_BITS-1:0] : k_rdata;
    assign cand   = sw_act_reg && !vis && (rch || upd);
    assign better = cand && (!best_found_reg || $signed(k_new) < $signed(best_key_reg));

    assign k_we    = upd;
    assign k_waddr = sw_v_reg;
    assign k_wdata = k_new;

    mstp_ram #(
        .WIDTH (EW),
        .DEPTH (NODE_COUNT * NODE_COUNT)
    ) u_edge_ram (
        .aclk  (aclk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    mstp_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (NODE_COUNT)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (k_wdata),
        .raddr (v_reg),
        .rdata (k_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg    <= '0;
            ld_act_reg     <= 1'b0;
            fw_valid_reg   <= 1'b0;
            sw_act_reg     <= 1'b0;
            v_reg          <= '0;
            visited_reg    <= '0;
            reach_reg      <= '0;
            best_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.clr_write) begin
                clr_cnt_reg <= (clr_cnt_reg == CLR_LAST) ? '0 : clr_cnt_reg + 1'b1;
            end
            ld_act_reg   <= in_take;
            fw_valid_reg <= ld_write;
            sw_act_reg   <= cmd.issue;

            if (cmd.issue) begin
                v_reg <= (v_reg == V_LAST) ? '0 : v_reg + 1'b1;
            end
            if (upd) begin
                reach_reg[sw_v_reg] <= 1'b1;
            end
            if (better) begin
                best_found_reg <= 1'b1;
            end

            if (cmd.run_init) begin
                v_reg          <= '0;
                best_found_reg <= 1'b0;
                pend_valid_reg <= 1'b0;
                if (root_ok) begin
                    visited_reg[NW'(root_reg)] <= 1'b1;
                end
            end
            if (cmd.pick) begin
                v_reg                      <= '0;
                best_found_reg             <= 1'b0;
                pend_valid_reg             <= 1'b1;
                visited_reg[best_node_reg] <= 1'b1;
            end

            if (cmd.pick && pend_valid_reg) begin
                m_valid_reg <= 1'b1;
            end else if (cmd.finish) begin
                m_valid_reg    <= 1'b1;
                visited_reg    <= '0;
                reach_reg      <= '0;
                pend_valid_reg <= 1'b0;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ld_addr_reg <= in_addr;
            ld_w_reg    <= in_edge_weight;
            root_reg    <= in_start_node;
        end
        if (ld_write) begin
            fw_addr_reg <= ld_addr_reg;
            fw_w_reg    <= ld_w_reg;
        end
        sw_v_reg <= v_reg;
        if (better) begin
            best_node_reg <= sw_v_reg;
            best_key_reg  <= k_new;
        end
        if (cmd.run_init) begin
            u_reg <= NW'(root_reg);
        end
        if (cmd.pick) begin
            u_reg         <= best_node_reg;
            pend_node_reg <= best_node_reg;
            pend_w_reg    <= best_key_reg;
        end
        if (cmd.pick && pend_valid_reg) begin
            m_node_reg  <= NFB'(pend_node_reg);
            m_w_reg     <= pend_w_reg;
            m_empty_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end else if (cmd.finish) begin
            m_node_reg  <= pend_valid_reg ? NFB'(pend_node_reg) : '0;
            m_w_reg     <= pend_valid_reg ? pend_w_reg : '0;
            m_empty_reg <= !pend_valid_reg;
            m_last_reg  <= 1'b1;
        end
    end

    assign status.clr_done   = (clr_cnt_reg == CLR_LAST);
    assign status.v_last     = (v_reg == V_LAST);
    assign status.best_found = best_found_reg;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;
    assign status.root_ok    = root_ok;

    assign m_tvalid        = m_valid_reg;
    assign out_tree_node   = m_node_reg;
    assign out_tree_weight = m_w_reg;
    assign out_tree_empty  = m_empty_reg;
    assign out_last_result = m_last_reg;

endmodule

// ===== rtl/minimum_spanning_tree_prim.sv =====
`timescale 1ns / 1ps
// Top level of the Prim minimum spanning tree block: stream ports and packing.
// Depends on mstp_pkg, mstp_ctrl, mstp_dpath (which holds two mstp_ram instances).
//
// Edge requests are taken one per clock cycle while loading, into an upper-triangle weight
// store of NODE_COUNT*NODE_COUNT entries; a repeated node pair keeps the smaller weight and
// self-loops or endpoints at or above NODE_COUNT are dropped. The request with tlast set
// starts the run from its start node. Each Prim step sweeps the root's or newest node's
// row of the weight store through its single read port, one node per cycle, and before
// picking the next node it waits while a pending tree edge cannot enter the output register.
// Tree edges leave in visit order, tlast on the final one; a tree without edges gives one
// result with tuser set. After reset and after every run a clearing pass writes the whole
// weight store, during which no request is accepted.
module minimum_spanning_tree_prim #(
    parameter int NODE_COUNT  = mstp_pkg::NODE_COUNT_DEF,
    parameter int WEIGHT_BITS = mstp_pkg::WEIGHT_BITS_DEF,
    localparam int NFB   = mstp_pkg::NODE_FIELD_BITS,
    localparam int S_RAW = 3 * NFB + WEIGHT_BITS,
    localparam int S_DW  = ((S_RAW + 7) / 8) * 8,
    localparam int M_RAW = NFB + WEIGHT_BITS,
    localparam int M_DW  = ((M_RAW + 7) / 8) * 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    // node_a, node_b, edge_weight, start_node, zero fill
    input  logic [S_DW-1:0] s_tdata,
    // edge_valid
    input  logic            s_tuser,
    input  logic            s_tlast,
    output logic            m_tvalid,
    input  logic            m_tready,
    // tree_node, tree_weight, zero fill
    output logic [M_DW-1:0] m_tdata,
    // tree_empty
    output logic            m_tuser,
    output logic            m_tlast
);

    mstp_pkg::cmd_t    cmd;
    mstp_pkg::status_t status;

    logic [NFB-1:0]                node_a;
    logic [NFB-1:0]                node_b;
    logic signed [WEIGHT_BITS-1:0] edge_weight;
    logic [NFB-1:0]                start_node;
    logic [NFB-1:0]                tree_node;
    logic signed [WEIGHT_BITS-1:0] tree_weight;

    assign node_a      = s_tdata[NFB-1:0];
    assign node_b      = s_tdata[2*NFB-1:NFB];
    assign edge_weight = s_tdata[2*NFB+WEIGHT_BITS-1:2*NFB];
    assign start_node  = s_tdata[S_RAW-1:2*NFB+WEIGHT_BITS];

    assign m_tdata = M_DW'({tree_weight, tree_node});

    mstp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mstp_dpath #(
        .NODE_COUNT  (NODE_COUNT),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .in_edge_valid   (s_tuser),
        .in_node_a       (node_a),
        .in_node_b       (node_b),
        .in_edge_weight  (edge_weight),
        .in_start_node   (start_node),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .out_tree_node   (tree_node),
        .out_tree_weight (tree_weight),
        .out_tree_empty  (m_tuser),
        .out_last_result (m_tlast)
    );

endmodule

// ===== verif/tb_minimum_spanning_tree_prim.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for minimum_spanning_tree_prim: edge requests in, tree edges out.
// Depends on mstp_pkg and the RTL below rtl/; predicts each run with a local Prim model.
module tb_minimum_spanning_tree_prim;

    localparam int NODES       = mstp_pkg::NODE_COUNT_DEF;
    localparam int S_DW        = 40;
    localparam int M_DW        = 24;
    localparam int HOLD_CYCLES = 3000;
    localparam int QUIET_LIMIT = 40000;
    localparam int ITEM_TARGET = 250;

    typedef logic signed [15:0] weight_t;

    typedef struct {
        logic [5:0] node;
        logic [15:0] weight;
        logic       empty;
        logic       is_last;
    } tree_rec_t;

    logic            aclk     = 1'b0;
    logic            aresetn  = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    // node_a, node_b, edge_weight, start_node, zero fill
    logic [S_DW-1:0] s_tdata  = '0;
    // edge_valid
    logic            s_tuser  = 1'b0;
    logic            s_tlast  = 1'b0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    // tree_node, tree_weight, zero fill
    logic [M_DW-1:0] m_tdata;
    // tree_empty
    logic            m_tuser;
    logic            m_tlast;

    bit        edge_known [NODES][NODES];
    weight_t   edge_w     [NODES][NODES];
    tree_rec_t tree_q[$];

    int sent_items = 0;
    int err_count  = 0;
    int quiet      = 0;
    bit steady     = 1'b0;
    bit hold_req   = 1'b0;

    minimum_spanning_tree_prim uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic grow_tree(input bit [5:0] root);
        bit        seen  [NODES];
        bit        reach [NODES];
        weight_t   key   [NODES];
        tree_rec_t run_q[$];
        tree_rec_t rec;
        int        u;
        int        pick;
        bit        found;
        seen  = '{default: 1'b0};
        reach = '{default: 1'b0};
        key   = '{default: '0};
        pick  = 0;
        u = root;
        seen[u] = 1'b1;
        forever begin
            for (int v = 0; v < NODES; v++) begin
                if (!seen[v] && edge_known[u][v] && (!reach[v] || edge_w[u][v] < key[v])) begin
                    key[v]   = edge_w[u][v];
                    reach[v] = 1'b1;
                end
            end
            found = 1'b0;
            for (int v = 0; v < NODES; v++) begin
                if (!seen[v] && reach[v] && (!found || key[v] < key[pick])) begin
                    pick  = v;
                    found = 1'b1;
                end
            end
            if (!found)
                break;
            seen[pick]  = 1'b1;
            rec.node    = 6'(pick);
            rec.weight  = key[pick];
            rec.empty   = 1'b0;
            rec.is_last = 1'b0;
            run_q       = {run_q, rec};
            u = pick;
        end
        if (run_q.size() == 0) begin
            rec.node    = '0;
            rec.weight  = '0;
            rec.empty   = 1'b1;
            rec.is_last = 1'b1;
            run_q       = {run_q, rec};
        end else begin
            run_q[run_q.size() - 1].is_last = 1'b1;
        end
        tree_q = {tree_q, run_q};
    endtask

    task automatic predict_request(input bit ev, input bit [5:0] a, input bit [5:0] b,
                                   input weight_t w, input bit [5:0] root, input bit lst);
        if (ev && a != b && (!edge_known[a][b] || w < edge_w[a][b])) begin
            edge_known[a][b] = 1'b1;
            edge_known[b][a] = 1'b1;
            edge_w[a][b]     = w;
            edge_w[b][a]     = w;
        end
        if (lst) begin
            grow_tree(root);
            edge_known = '{default: '{default: 1'b0}};
        end
    endtask

    task automatic send_request(input bit ev, input bit [5:0] a, input bit [5:0] b,
                                input bit [15:0] w, input bit [5:0] root, input bit lst);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, root, w, b, a};
        s_tuser  <= ev;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_request(ev, a, b, weight_t'(w), root, lst);
        sent_items++;
    endtask

    task automatic random_graph(input int n_edges);
        int      span;
        int      lo;
        bit      wide;
        bit [5:0] a;
        bit [5:0] b;
        bit [5:0] root;
        weight_t w;
        span = $urandom_range(2, NODES);
        lo   = $urandom_range(0, NODES - span);
        wide = $urandom_range(0, 1);
        for (int i = 0; i < n_edges; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_request(1'b0, 6'($urandom), 6'($urandom), 16'($urandom), 6'($urandom),
                             1'b0);
            a = 6'(lo + $urandom_range(0, span - 1));
            b = 6'(lo + $urandom_range(0, span - 1));
            w = wide ? weight_t'($urandom) : weight_t'($urandom_range(0, 6) - 3);
            send_request(1'b1, a, b, w, 6'($urandom), 1'b0);
        end
        root = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'(lo + $urandom_range(0, span - 1));
        a = 6'(lo + $urandom_range(0, span - 1));
        b = 6'(lo + $urandom_range(0, span - 1));
        w = wide ? weight_t'($urandom) : weight_t'($urandom_range(0, 6) - 3);
        send_request(1'($urandom_range(0, 1)), a, b, w, root, 1'b1);
    endtask

    task automatic test_empty_trees;
        send_request(1'b0, 6'd0, 6'd0, 16'h0000, 6'd0, 1'b1);
        send_request(1'b1, 6'd7, 6'd7, 16'h0005, 6'd7, 1'b1);
        send_request(1'b1, 6'd1, 6'd2, 16'h0005, 6'd0, 1'b0);
        send_request(1'b0, 6'd63, 6'd63, 16'hffff, 6'd63, 1'b1);
    endtask

    task automatic test_weight_extremes;
        send_request(1'b1, 6'd0, 6'd63, 16'h7fff, 6'd0, 1'b0);
        send_request(1'b1, 6'd63, 6'd0, 16'h8000, 6'd0, 1'b0);
        send_request(1'b1, 6'd63, 6'd62, 16'h7fff, 6'd0, 1'b0);
        send_request(1'b0, 6'd0, 6'd62, 16'h8000, 6'd63, 1'b0);
        send_request(1'b1, 6'd62, 6'd0, 16'd100, 6'd63, 1'b1);
    endtask

    task automatic test_ties_and_components;
        send_request(1'b1, 6'd10, 6'd40, 16'd3, 6'd0, 1'b0);
        send_request(1'b1, 6'd20, 6'd10, 16'd3, 6'd0, 1'b0);
        send_request(1'b1, 6'd10, 6'd30, 16'd3, 6'd0, 1'b0);
        send_request(1'b1, 6'd40, 6'd41, 16'hffff, 6'd0, 1'b0);
        send_request(1'b1, 6'd50, 6'd51, 16'd0, 6'd0, 1'b0);
        send_request(1'b1, 6'd41, 6'd30, 16'd3, 6'd0, 1'b0);
        send_request(1'b0, 6'd0, 6'd0, 16'd0, 6'd10, 1'b1);
    endtask

    task automatic test_backpressure;
        steady   = 1'b1;
        hold_req = 1'b1;
        random_graph(12);
        random_graph(12);
        steady = 1'b0;
    endtask

    task automatic test_steady_stream;
        steady = 1'b1;
        repeat (3) random_graph($urandom_range(4, 16));
        steady = 1'b0;
    endtask

    task automatic test_random_graphs;
        while (sent_items < ITEM_TARGET)
            random_graph($urandom_range(1, 16));
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_trees;
        test_weight_extremes;
        test_ties_and_components;
        test_backpressure;
        test_steady_stream;
        test_random_graphs;
        s_tvalid <= 1'b0;
        while (tree_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin : result_sink
        int h;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        m_tready <= 1'b1;
        @(posedge aclk);
        forever begin
            h = steady ? 0 : $urandom_range(0, 3);
            if (hold_req) begin
                hold_req = 1'b0;
                h = HOLD_CYCLES;
            end
            if (h > 0) begin
                m_tready <= 1'b0;
                repeat (h) @(posedge aclk);
                m_tready <= 1'b1;
            end
            @(posedge aclk);
            while (!(m_tvalid && m_tready) && !hold_req) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        tree_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (tree_q.size() == 0) begin
                $error("unexpected result: tree_node=%0d tree_weight=%0d tree_empty=%0b",
                       m_tdata[5:0], $signed(m_tdata[21:6]), m_tuser);
                err_count++;
            end else begin
                want = tree_q.pop_front();
                if (m_tdata[5:0] !== want.node) begin
                    $error("tree_node expected %0d actual %0d", want.node, m_tdata[5:0]);
                    err_count++;
                end
                if (m_tdata[21:6] !== want.weight) begin
                    $error("tree_weight expected %0d actual %0d",
                           $signed(want.weight), $signed(m_tdata[21:6]));
                    err_count++;
                end
                if (m_tuser !== want.empty) begin
                    $error("tree_empty expected %0b actual %0b", want.empty, m_tuser);
                    err_count++;
                end
                if (m_tlast !== want.is_last) begin
                    $error("last_result expected %0b actual %0b", want.is_last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet + 1 >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

endmodule

// ===== sim.f =====
rtl/mstp_pkg.sv
rtl/mstp_ram.sv
rtl/mstp_ctrl.sv
rtl/mstp_dpath.sv
rtl/minimum_spanning_tree_prim.sv
verif/tb_minimum_spanning_tree_prim.sv
